FILE: rtl/dcd_pkg.sv
// Shared types and constants for the drive command decoder.
// Used by every module of the block; depends on nothing else.
package dcd_pkg;

  // Widths of the request and result fields
  localparam int unsigned OpW     = 2;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned EchoW   = 16;
  localparam int unsigned DirW    = 4;
  localparam int unsigned DutyW   = 8;
  localparam int unsigned LedW    = 5;
  localparam int unsigned TickW   = 4;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 16;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_SPEED_ONE   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_SPEED_TWO   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_SPEED_THREE = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_TICK_LIMIT  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_NEAR_COUNT  = 3'd4;

  // Configuration reset values
  localparam logic [DutyW-1:0] SPEED_ONE_RST   = 8'd100;
  localparam logic [DutyW-1:0] SPEED_TWO_RST   = 8'd170;
  localparam logic [DutyW-1:0] SPEED_THREE_RST = 8'd240;
  localparam logic [TickW-1:0] TICK_LIMIT_RST  = 4'd10;
  localparam logic [EchoW-1:0] NEAR_COUNT_RST  = 16'd583;

  // H-bridge patterns
  localparam logic [DirW-1:0] DIR_STOP  = 4'h0;
  localparam logic [DirW-1:0] DIR_RIGHT = 4'h1;
  localparam logic [DirW-1:0] DIR_LEFT  = 4'h4;
  localparam logic [DirW-1:0] DIR_FWD   = 4'h5;
  localparam logic [DirW-1:0] DIR_REV   = 4'hA;

  // LED patterns
  localparam logic [LedW-1:0] LED_CMD_OR = 5'h03;
  localparam logic [LedW-1:0] LED_IDLE   = 5'h01;
  localparam logic [LedW-1:0] LED_SPEED1 = 5'h07;
  localparam logic [LedW-1:0] LED_SPEED2 = 5'h0B;
  localparam logic [LedW-1:0] LED_SPEED3 = 5'h13;

  // Command characters
  localparam logic [ByteW-1:0] CMD_A = 8'h61;
  localparam logic [ByteW-1:0] CMD_B = 8'h62;
  localparam logic [ByteW-1:0] CMD_C = 8'h63;
  localparam logic [ByteW-1:0] CMD_D = 8'h64;
  localparam logic [ByteW-1:0] CMD_E = 8'h65;
  localparam logic [ByteW-1:0] CMD_F = 8'h66;
  localparam logic [ByteW-1:0] CMD_G = 8'h67;
  localparam logic [ByteW-1:0] CMD_H = 8'h68;
  localparam logic [ByteW-1:0] CMD_I = 8'h69;
  localparam logic [ByteW-1:0] CMD_J = 8'h6A;
  localparam logic [ByteW-1:0] CMD_K = 8'h6B;
  localparam logic [ByteW-1:0] CMD_L = 8'h6C;
  localparam logic [ByteW-1:0] CMD_M = 8'h6D;
  localparam logic [ByteW-1:0] CMD_N = 8'h6E;
  localparam logic [ByteW-1:0] CMD_O = 8'h6F;
  localparam logic [ByteW-1:0] CMD_P = 8'h70;

  typedef enum logic [OpW-1:0] {
    OP_CMD  = 2'd0,
    OP_TICK = 2'd1,
    OP_ECHO = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef struct packed {
    logic [DutyW-1:0] speed_one;
    logic [DutyW-1:0] speed_two;
    logic [DutyW-1:0] speed_three;
    logic [TickW-1:0] tick_limit;
    logic [EchoW-1:0] near_count;
  } cfg_t;

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [ByteW-1:0] command_byte;
    logic [EchoW-1:0] echo_count;
  } item_t;

  typedef struct packed {
    logic [DirW-1:0]  direction_bits;
    logic [DutyW-1:0] duty_left;
    logic [DutyW-1:0] duty_right;
    logic [LedW-1:0]  led_pattern;
    logic             auto_on;
    logic             report_on;
  } result_t;

  // Handshake between the input register, the decode core and the result register
  typedef struct packed {
    logic item_valid;  // input register holds a request
    logic advance;     // result register can take a new value this cycle
  } pipe_ctrl_t;

endpackage

FILE: rtl/dcd_cfg_regs.sv
// Configuration register file of the drive command decoder.
// Depends on dcd_pkg for the register indexes and reset values.
module dcd_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [dcd_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [dcd_pkg::CfgW-1:0]        cfg_data,
  output dcd_pkg::cfg_t                   cfg
);
  import dcd_pkg::*;

  // Write one register per enabled cycle; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.speed_one   <= SPEED_ONE_RST;
      cfg.speed_two   <= SPEED_TWO_RST;
      cfg.speed_three <= SPEED_THREE_RST;
      cfg.tick_limit  <= TICK_LIMIT_RST;
      cfg.near_count  <= NEAR_COUNT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_SPEED_ONE:   cfg.speed_one   <= cfg_data[DutyW-1:0];
        CFG_SPEED_TWO:   cfg.speed_two   <= cfg_data[DutyW-1:0];
        CFG_SPEED_THREE: cfg.speed_three <= cfg_data[DutyW-1:0];
        CFG_TICK_LIMIT:  cfg.tick_limit  <= cfg_data[TickW-1:0];
        CFG_NEAR_COUNT:  cfg.near_count  <= cfg_data[EchoW-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/dcd_in_stage.sv
// Input register of the drive command decoder: holds one request until
// the decode core takes it. Depends on dcd_pkg for the item type.
module dcd_in_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  dcd_pkg::item_t       in_item,
  input  logic                 advance,
  output dcd_pkg::pipe_ctrl_t  ctrl,
  output dcd_pkg::item_t       item
);
  import dcd_pkg::*;

  logic item_valid;
  logic accept;

  // Stall only when the held request cannot move on
  assign in_stall = item_valid && !advance;
  assign accept   = in_valid && !in_stall;

  assign ctrl.item_valid = item_valid;
  assign ctrl.advance    = advance;

  // Hold the valid flag; drop it once the request moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  // Capture the payload on acceptance
  always_ff @(posedge clk) begin
    if (accept) begin
      item <= in_item;
    end
  end

endmodule

FILE: rtl/dcd_core.sv
// Decode core: drive, speed, LED, tick and mode state, updated once per request.
// Depends on dcd_pkg for constants, command codes and struct types.
module dcd_core (
  input  logic                 clk,
  input  logic                 rst,
  input  dcd_pkg::pipe_ctrl_t  ctrl,
  input  dcd_pkg::item_t       item,
  input  dcd_pkg::cfg_t        cfg,
  output dcd_pkg::result_t     result_next
);
  import dcd_pkg::*;

  logic [DirW-1:0]  direction_reg, direction_reg_next;
  logic [DutyW-1:0] duty_left_reg, duty_left_reg_next;
  logic [DutyW-1:0] duty_right_reg, duty_right_reg_next;
  logic [DutyW-1:0] speed_reg, speed_reg_next;
  logic [LedW-1:0]  led_reg, led_reg_next;
  logic [TickW-1:0] tick_count, tick_count_next;
  logic             auto_flag, auto_flag_next;
  logic             report_flag, report_flag_next;

  logic [DutyW-1:0] full_duty;
  logic [DutyW-1:0] half_duty;
  logic [TickW-1:0] tick_inc;
  logic             fire;

  assign fire      = ctrl.item_valid && ctrl.advance;
  assign full_duty = speed_reg;
  assign half_duty = {1'b0, speed_reg[DutyW-1:1]};
  assign tick_inc  = tick_count + 4'd1;

  // Next state for the request in the input register
  always_comb begin
    direction_reg_next  = direction_reg;
    duty_left_reg_next  = duty_left_reg;
    duty_right_reg_next = duty_right_reg;
    speed_reg_next      = speed_reg;
    led_reg_next        = led_reg;
    tick_count_next     = tick_count;
    auto_flag_next      = auto_flag;
    report_flag_next    = report_flag;
    unique case (op_t'(item.op))
      OP_CMD: begin
        led_reg_next    = led_reg | LED_CMD_OR;
        tick_count_next = '0;
        unique case (item.command_byte)
          CMD_A: begin
            direction_reg_next  = DIR_FWD;
            duty_left_reg_next  = half_duty;
            duty_right_reg_next = full_duty;
          end
          CMD_B: begin
            direction_reg_next  = DIR_FWD;
            duty_left_reg_next  = full_duty;
            duty_right_reg_next = full_duty;
          end
          CMD_C: begin
            direction_reg_next  = DIR_FWD;
            duty_left_reg_next  = full_duty;
            duty_right_reg_next = half_duty;
          end
          CMD_D: begin
            direction_reg_next  = DIR_LEFT;
            duty_left_reg_next  = '0;
            duty_right_reg_next = full_duty;
          end
          CMD_E: begin
            direction_reg_next  = DIR_STOP;
            duty_left_reg_next  = '0;
            duty_right_reg_next = '0;
          end
          CMD_F: begin
            direction_reg_next  = DIR_RIGHT;
            duty_left_reg_next  = full_duty;
            duty_right_reg_next = '0;
          end
          CMD_G: begin
            direction_reg_next  = DIR_REV;
            duty_left_reg_next  = full_duty;
            duty_right_reg_next = half_duty;
          end
          CMD_H: begin
            direction_reg_next  = DIR_REV;
            duty_left_reg_next  = full_duty;
            duty_right_reg_next = full_duty;
          end
          CMD_I: begin
            direction_reg_next  = DIR_REV;
            duty_left_reg_next  = half_duty;
            duty_right_reg_next = full_duty;
          end
          CMD_J: begin
            speed_reg_next = cfg.speed_one;
            led_reg_next   = LED_SPEED1;
          end
          CMD_K: begin
            speed_reg_next = cfg.speed_two;
            led_reg_next   = LED_SPEED2;
          end
          CMD_L: begin
            speed_reg_next = cfg.speed_three;
            led_reg_next   = LED_SPEED3;
          end
          CMD_M: auto_flag_next = 1'b1;
          CMD_N: begin
            auto_flag_next      = 1'b0;
            direction_reg_next  = DIR_STOP;
            duty_left_reg_next  = '0;
            duty_right_reg_next = '0;
          end
          CMD_O: report_flag_next = 1'b1;
          CMD_P: report_flag_next = 1'b0;
          default: ;
        endcase
      end
      OP_TICK: begin
        // Fall back to the idle pattern once the limit is reached
        if (tick_inc >= cfg.tick_limit) begin
          led_reg_next    = LED_IDLE;
          tick_count_next = '0;
        end else begin
          tick_count_next = tick_inc;
        end
      end
      OP_ECHO: begin
        if (auto_flag) begin
          if (item.echo_count < cfg.near_count) begin
            // Target near: charge at the top speed
            speed_reg_next      = cfg.speed_three;
            led_reg_next        = LED_SPEED3;
            direction_reg_next  = DIR_FWD;
            duty_left_reg_next  = cfg.speed_three;
            duty_right_reg_next = cfg.speed_three;
          end else begin
            // Target far: turn right at the low speed
            speed_reg_next      = cfg.speed_one;
            led_reg_next        = LED_SPEED1;
            direction_reg_next  = DIR_RIGHT;
            duty_left_reg_next  = cfg.speed_one;
            duty_right_reg_next = '0;
          end
        end
      end
      OP_NONE: ;
    endcase
  end

  // Result shows the state after the request
  assign result_next.direction_bits = direction_reg_next;
  assign result_next.duty_left      = duty_left_reg_next;
  assign result_next.duty_right     = duty_right_reg_next;
  assign result_next.led_pattern    = led_reg_next;
  assign result_next.auto_on        = auto_flag_next;
  assign result_next.report_on      = report_flag_next;

  // Commit the state when the request moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      direction_reg  <= '0;
      duty_left_reg  <= '0;
      duty_right_reg <= '0;
      speed_reg      <= SPEED_ONE_RST;
      led_reg        <= '0;
      tick_count     <= '0;
      auto_flag      <= 1'b0;
      report_flag    <= 1'b0;
    end else if (fire) begin
      direction_reg  <= direction_reg_next;
      duty_left_reg  <= duty_left_reg_next;
      duty_right_reg <= duty_right_reg_next;
      speed_reg      <= speed_reg_next;
      led_reg        <= led_reg_next;
      tick_count     <= tick_count_next;
      auto_flag      <= auto_flag_next;
      report_flag    <= report_flag_next;
    end
  end

endmodule

FILE: rtl/dcd_out_stage.sv
// Result register of the drive command decoder with its valid/stall handshake.
// Depends on dcd_pkg for the result and control types.
module dcd_out_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  input  dcd_pkg::result_t     result_next,
  output logic                 advance,
  output logic                 out_valid,
  input  logic                 out_stall,
  output dcd_pkg::result_t     result
);
  import dcd_pkg::*;

  // Free when empty or when the held result leaves this cycle
  assign advance = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= item_valid;
    end
  end

  // Load a new result only on a real transfer
  always_ff @(posedge clk) begin
    if (advance && item_valid) begin
      result <= result_next;
    end
  end

endmodule

FILE: rtl/drive_command_decoder_top.sv
// Drive command decoder top level: ports, configuration and the request pipeline.
// Depends on dcd_pkg, dcd_cfg_regs, dcd_in_stage, dcd_core and dcd_out_stage.
//
// Takes one request per clock while not stalled (command byte, timer tick or echo
// count) and returns one result per request: the H-bridge pattern, both PWM
// duties, the LED pattern and the auto and report flags as they stand after that
// request. An accepted request is held in the input register and then passes
// through the decode core into the result register. A stall on the result side
// holds the result register and then the input register, so up to two requests
// are in flight. Configuration registers take effect for requests decoded after
// the write and come out of reset at their default values; there is no start-up
// sweep.
module drive_command_decoder_top (
  input  logic                          clk,
  input  logic                          rst,
  // request channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [dcd_pkg::OpW-1:0]       op,
  input  logic [dcd_pkg::ByteW-1:0]     command_byte,
  input  logic [dcd_pkg::EchoW-1:0]     echo_count,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [dcd_pkg::DirW-1:0]      direction_bits,
  output logic [dcd_pkg::DutyW-1:0]     duty_left,
  output logic [dcd_pkg::DutyW-1:0]     duty_right,
  output logic [dcd_pkg::LedW-1:0]      led_pattern,
  output logic                          auto_on,
  output logic                          report_on,
  // configuration port
  input  logic                          cfg_write,
  input  logic [dcd_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [dcd_pkg::CfgW-1:0]      cfg_data
);
  import dcd_pkg::*;

  cfg_t       cfg;
  item_t      in_item;
  item_t      item;
  pipe_ctrl_t ctrl;
  logic       advance;
  result_t    result_next;
  result_t    result;

  assign in_item.op           = op;
  assign in_item.command_byte = command_byte;
  assign in_item.echo_count   = echo_count;

  dcd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dcd_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .advance  (advance),
    .ctrl     (ctrl),
    .item     (item)
  );

  dcd_core u_core (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .item        (item),
    .cfg         (cfg),
    .result_next (result_next)
  );

  dcd_out_stage u_out (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (ctrl.item_valid),
    .result_next (result_next),
    .advance     (advance),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .result      (result)
  );

  assign direction_bits = result.direction_bits;
  assign duty_left      = result.duty_left;
  assign duty_right     = result.duty_right;
  assign led_pattern    = result.led_pattern;
  assign auto_on        = result.auto_on;
  assign report_on      = result.report_on;

endmodule

FILE: rtl/dcd_checker.sv
// Port-level assertions for the drive command decoder, bound to the top level.
// Depends on dcd_pkg for widths and drive pattern constants.
module dcd_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [dcd_pkg::DirW-1:0]      direction_bits,
  input logic [dcd_pkg::DutyW-1:0]     duty_left,
  input logic [dcd_pkg::DutyW-1:0]     duty_right,
  input logic [dcd_pkg::LedW-1:0]      led_pattern,
  input logic                          auto_on,
  input logic                          report_on
);
  import dcd_pkg::*;

  // A result stalled at the output holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(direction_bits) &&
      $stable(duty_left) && $stable(duty_right) && $stable(led_pattern) &&
      $stable(auto_on) && $stable(report_on))
    else $error("result changed while stalled");

  // The request side never stalls while the result side is free
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    (!out_valid || !out_stall) |-> !in_stall)
    else $error("request stalled with result register free");

  // Only the defined H-bridge patterns leave the block
  a_dir_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (direction_bits == DIR_STOP || direction_bits == DIR_RIGHT ||
      direction_bits == DIR_LEFT || direction_bits == DIR_FWD ||
      direction_bits == DIR_REV))
    else $error("undefined direction pattern");

  // Idle wheels carry no duty for the pattern shown
  a_duty_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (direction_bits != DIR_STOP || (duty_left == '0 && duty_right == '0)) &&
      (direction_bits != DIR_RIGHT || duty_right == '0) &&
      (direction_bits != DIR_LEFT || duty_left == '0))
    else $error("duty does not match direction");

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind drive_command_decoder_top dcd_checker u_dcd_checker (.*);
